### rtl/core/assert_macros.svh
// Assertion helpers used by the allocator engine.
// Both macros expect signals named clk and rst_n in the scope where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define PPA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define PPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/ppa_pkg.sv
package ppa_pkg;

    localparam int ADDR_W      = 40;
    localparam int CPU_FIELD_W = 3;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 40;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_REGION_START = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_TOP   = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NO_MEM   = 2'd1,
        STATUS_BAD_ADDR = 2'd2
    } status_t;

    typedef struct packed {
        logic                   operation;
        logic [CPU_FIELD_W-1:0] requesting_cpu;
        logic [ADDR_W-1:0]      page_address;
    } req_t;

    typedef struct packed {
        status_t                status;
        logic [ADDR_W-1:0]      granted_address;
        logic                   stolen;
        logic [CPU_FIELD_W-1:0] source_cpu;
    } rsp_t;

    typedef struct packed {
        logic [ADDR_W-1:0] region_start;
        logic [ADDR_W-1:0] region_top;
    } cfg_t;

    // Head lookup result for the request held by the engine.
    typedef struct packed {
        logic cpu_ok;
        logic own_valid;
        logic found;
        logic stolen;
    } head_sel_t;

    typedef struct packed {
        logic en;
        logic valid;
    } head_wr_t;

endpackage

### rtl/core/ppa_stream_if.sv
interface ppa_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### rtl/core/per_cpu_page_allocator.sv
// Per-CPU page allocator: one LIFO free list per CPU, kept as head registers plus a
// next-page link memory. A free is checked against region_start, region_top, page
// alignment and the page count, then pushed onto the requesting CPU's list. An
// allocate pops the requesting CPU's list, or steals from the lowest-numbered CPU with
// a free page. A free, and an allocate that finds every list empty, posts its result
// from the execute state. An allocate that gets a page first reads the link memory,
// then updates the head in the cycle that posts its result. The engine holds one
// request at a time; it takes a new one only when idle or while the previous allocate
// posts its result. A request is also taken while a result waits at the output; its
// own result then waits until the output is free. Lists are empty after reset; the
// host frees the initial page range. Write the region registers only while no request
// is open.
module per_cpu_page_allocator import ppa_pkg::*; #(
    parameter int CPU_COUNT = 8,
    parameter int NUM_PAGES = 32768,
    parameter int PAGE_BYTES_LOG2 = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    ppa_stream_if.sink            req,
    ppa_stream_if.source          rsp
);

    localparam int IDX_W  = $clog2(NUM_PAGES);
    localparam int CPU_W  = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
    localparam int BASE_W = ADDR_W + 1 - PAGE_BYTES_LOG2;
    localparam logic [ADDR_W:0] PAGE_MASK = (ADDR_W + 1)'((64'd1 << PAGE_BYTES_LOG2) - 64'd1);

    cfg_t                   cfg_reg;
    logic [BASE_W-1:0]      base_page_reg;
    logic [ADDR_W:0]        base_sum;

    logic [CPU_FIELD_W-1:0] head_cpu;
    head_sel_t              sel;
    logic [IDX_W-1:0]       own_idx;
    logic [CPU_W-1:0]       src_cpu;
    logic [IDX_W-1:0]       src_idx;
    head_wr_t               head_wr;
    logic [CPU_W-1:0]       head_wr_cpu;
    logic [IDX_W-1:0]       head_wr_idx;
    logic                   mem_we;
    logic [IDX_W-1:0]       mem_waddr;
    logic [IDX_W:0]         mem_wdata;
    logic                   mem_re;
    logic [IDX_W-1:0]       mem_raddr;
    logic [IDX_W:0]         mem_rdata;

    // The first whole page at or above region_start is page index zero.
    assign base_sum = {1'b0, cfg_data} + PAGE_MASK;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= '0;
            base_page_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_REGION_START:
                begin
                    cfg_reg.region_start <= cfg_data;
                    base_page_reg        <= base_sum[ADDR_W:PAGE_BYTES_LOG2];
                end
                REG_REGION_TOP:
                begin
                    cfg_reg.region_top <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    ppa_heads #(
        .CPU_COUNT(CPU_COUNT),
        .IDX_W(IDX_W)
    ) u_heads (
        .clk(clk),
        .rst_n(rst_n),
        .req_cpu(head_cpu),
        .sel(sel),
        .own_idx(own_idx),
        .src_cpu(src_cpu),
        .src_idx(src_idx),
        .wr(head_wr),
        .wr_cpu(head_wr_cpu),
        .wr_idx(head_wr_idx)
    );

    ppa_link_mem #(
        .DEPTH(NUM_PAGES),
        .WIDTH(IDX_W + 1)
    ) u_links (
        .clk(clk),
        .we(mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .re(mem_re),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    ppa_engine #(
        .CPU_COUNT(CPU_COUNT),
        .NUM_PAGES(NUM_PAGES),
        .PAGE_BYTES_LOG2(PAGE_BYTES_LOG2)
    ) u_engine (
        .clk(clk),
        .rst_n(rst_n),
        .req(req),
        .rsp(rsp),
        .cfg(cfg_reg),
        .base_page(base_page_reg),
        .head_cpu(head_cpu),
        .sel(sel),
        .own_idx(own_idx),
        .src_cpu(src_cpu),
        .src_idx(src_idx),
        .head_wr(head_wr),
        .head_wr_cpu(head_wr_cpu),
        .head_wr_idx(head_wr_idx),
        .mem_we(mem_we),
        .mem_waddr(mem_waddr),
        .mem_wdata(mem_wdata),
        .mem_re(mem_re),
        .mem_raddr(mem_raddr),
        .mem_rdata(mem_rdata)
    );

endmodule

### rtl/core/ppa_link_mem.sv
module ppa_link_mem #(
    parameter int DEPTH = 32768,
    parameter int WIDTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/ppa_heads.sv
module ppa_heads import ppa_pkg::*; #(
    parameter int CPU_COUNT = 8,
    parameter int IDX_W = 15,
    localparam int CPU_W = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [CPU_FIELD_W-1:0] req_cpu,
    output head_sel_t              sel,
    output logic [IDX_W-1:0]       own_idx,
    output logic [CPU_W-1:0]       src_cpu,
    output logic [IDX_W-1:0]       src_idx,
    input  head_wr_t               wr,
    input  logic [CPU_W-1:0]       wr_cpu,
    input  logic [IDX_W-1:0]       wr_idx
);

    logic [CPU_COUNT-1:0] head_valid_reg;
    logic [IDX_W-1:0]     head_idx_reg [CPU_COUNT];
    logic [CPU_W-1:0]     own_cpu;
    logic [CPU_W-1:0]     first_cpu;
    logic                 any_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= '0;
        end
        else if (wr.en)
        begin
            head_valid_reg[wr_cpu] <= wr.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            head_idx_reg[wr_cpu] <= wr_idx;
        end
    end

    // Lowest-numbered CPU with a non-empty list; the steal scan starts at CPU 0.
    always_comb
    begin
        first_cpu = '0;
        any_valid = 1'b0;
        for (int i = CPU_COUNT - 1; i >= 0; i--)
        begin
            if (head_valid_reg[i])
            begin
                first_cpu = CPU_W'(i);
                any_valid = 1'b1;
            end
        end
    end

    assign own_cpu       = CPU_W'(req_cpu);
    assign sel.cpu_ok    = int'(req_cpu) < CPU_COUNT;
    assign sel.own_valid = sel.cpu_ok && head_valid_reg[own_cpu];
    assign sel.found     = sel.own_valid || any_valid;
    assign src_cpu       = sel.own_valid ? own_cpu : first_cpu;
    assign sel.stolen    = int'(src_cpu) != int'(req_cpu);
    assign src_idx       = head_idx_reg[src_cpu];
    assign own_idx       = head_idx_reg[own_cpu];

endmodule

### rtl/core/ppa_engine.sv
`include "assert_macros.svh"

module ppa_engine import ppa_pkg::*; #(
    parameter int CPU_COUNT = 8,
    parameter int NUM_PAGES = 32768,
    parameter int PAGE_BYTES_LOG2 = 12,
    localparam int IDX_W = $clog2(NUM_PAGES),
    localparam int CPU_W = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1,
    localparam int BASE_W = ADDR_W + 1 - PAGE_BYTES_LOG2
) (
    input  logic                   clk,
    input  logic                   rst_n,
    ppa_stream_if.sink             req,
    ppa_stream_if.source           rsp,
    input  cfg_t                   cfg,
    input  logic [BASE_W-1:0]      base_page,
    output logic [CPU_FIELD_W-1:0] head_cpu,
    input  head_sel_t              sel,
    input  logic [IDX_W-1:0]       own_idx,
    input  logic [CPU_W-1:0]       src_cpu,
    input  logic [IDX_W-1:0]       src_idx,
    output head_wr_t               head_wr,
    output logic [CPU_W-1:0]       head_wr_cpu,
    output logic [IDX_W-1:0]       head_wr_idx,
    output logic                   mem_we,
    output logic [IDX_W-1:0]       mem_waddr,
    output logic [IDX_W:0]         mem_wdata,
    output logic                   mem_re,
    output logic [IDX_W-1:0]       mem_raddr,
    input  logic [IDX_W:0]         mem_rdata
);

    localparam int DIFF_W = ADDR_W + 2 - PAGE_BYTES_LOG2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FIN
    } state_t;

    state_t              state_reg;
    req_t                req_reg;
    rsp_t                rsp_reg;
    rsp_t                rsp_next;
    logic                out_valid_reg;
    logic [CPU_W-1:0]    pop_cpu_reg;
    logic [IDX_W-1:0]    pop_idx_reg;
    logic                pop_stolen_reg;

    logic                can_write;
    logic                accept;
    logic                free_ok;
    logic                fin_done;
    logic                load_result;
    logic [DIFF_W-1:0]   rel_diff;
    logic [ADDR_W:0]     page_sum;
    logic [CPU_W-1:0]    own_cpu;

    assign can_write = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE) || ((state_reg == S_FIN) && can_write);
    assign head_cpu  = req_reg.requesting_cpu;
    assign own_cpu   = CPU_W'(req_reg.requesting_cpu);

    // A borrow sets the top bit, so an address below the base also fails the bound check.
    assign rel_diff = DIFF_W'(req_reg.page_address[ADDR_W-1:PAGE_BYTES_LOG2])
                    - DIFF_W'(base_page);

    assign free_ok = (req_reg.page_address[PAGE_BYTES_LOG2-1:0] == '0)
                  && (req_reg.page_address >= cfg.region_start)
                  && (req_reg.page_address < cfg.region_top)
                  && sel.cpu_ok
                  && (rel_diff < DIFF_W'(NUM_PAGES));

    // Push: the freed page links to the old head and becomes the new head.
    assign mem_we    = (state_reg == S_EXEC) && (req_reg.operation == OP_FREE)
                    && can_write && free_ok;
    assign mem_waddr = IDX_W'(rel_diff);
    assign mem_wdata = {sel.own_valid, own_idx};

    // Pop: read the link of the selected head, then update that head in the cycle
    // that posts the result, which waits while the output is stalled.
    assign mem_re    = (state_reg == S_EXEC) && (req_reg.operation == OP_ALLOC) && sel.found;
    assign mem_raddr = src_idx;

    assign fin_done = (state_reg == S_FIN) && can_write;

    assign head_wr.en    = mem_we || fin_done;
    assign head_wr.valid = mem_we ? 1'b1 : mem_rdata[IDX_W];
    assign head_wr_cpu   = mem_we ? own_cpu : pop_cpu_reg;
    assign head_wr_idx   = mem_we ? IDX_W'(rel_diff) : mem_rdata[IDX_W-1:0];

    assign load_result = fin_done
                      || ((state_reg == S_EXEC) && can_write
                          && ((req_reg.operation == OP_FREE) || !sel.found));

    assign page_sum = (ADDR_W + 1)'(base_page) + (ADDR_W + 1)'(pop_idx_reg);

    always_comb
    begin
        rsp_next = '0;
        if (state_reg == S_FIN)
        begin
            rsp_next.status          = STATUS_OK;
            rsp_next.granted_address = ADDR_W'(page_sum << PAGE_BYTES_LOG2);
            rsp_next.stolen          = pop_stolen_reg;
            rsp_next.source_cpu      = CPU_FIELD_W'(pop_cpu_reg);
        end
        else if (req_reg.operation == OP_FREE)
        begin
            rsp_next.status = free_ok ? STATUS_OK : STATUS_BAD_ADDR;
        end
        else
        begin
            rsp_next.status = STATUS_NO_MEM;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            if (load_result)
            begin
                rsp_reg       <= rsp_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (mem_re)
                    begin
                        state_reg <= S_FIN;
                    end
                    else if (can_write)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_FIN:
                begin
                    if (can_write)
                    begin
                        state_reg <= accept ? S_EXEC : S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req.payload;
        end
        if (mem_re)
        begin
            pop_cpu_reg    <= src_cpu;
            pop_idx_reg    <= src_idx;
            pop_stolen_reg <= sel.stolen;
        end
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = rsp_reg;

    `PPA_ASSERT_NEXT(a_accept_to_exec, accept, state_reg == S_EXEC, "accepted beat not executed")
    `PPA_ASSERT(a_single_mem_access, !(mem_we && mem_re), "push and pop in one cycle")
    `PPA_ASSERT_NEXT(a_fin_only_alloc, mem_re, req_reg.operation == OP_ALLOC, "pop for a free")
    `PPA_ASSERT_NEXT(a_result_posted, load_result, out_valid_reg, "result not presented")

endmodule
